@@ hdl/cnf_pkg.sv @@
// shared types and constants for the console number formatter
`timescale 1ns / 1ps

package cnf_pkg;

	// default number of digit slots
	localparam int CNF_DIGIT_SLOTS = 10;

	// request codes
	localparam logic [1:0] ACT_CHAR = 2'd0;
	localparam logic [1:0] ACT_DEC  = 2'd1;
	localparam logic [1:0] ACT_HEX  = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	// console character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;

	// attribute after reset
	localparam logic [7:0] COLOR_RESET = 8'h0F;

	// request item
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] value;
	} cnf_cmd_t;

	// console character item
	typedef struct packed {
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic       last;
	} cnf_chr_t;

endpackage

@@ hdl/console_number_formatter.sv @@
// console number formatter top level: request decode, digit extraction and character output
`timescale 1ns / 1ps

// Turns print requests into console characters, one character per transfer.
// A request prints one character (CR or LF as CR LF, backspace as BS space BS),
// a 32-bit value as signed decimal, or a value as uppercase hex. The request
// port stalls while a request is being worked on; it takes the next request as
// soon as the last character sits in the output register. A character request
// emits its expanded characters in turn. A hex number is split digit by digit,
// then its characters are emitted. A decimal number is split by one shared
// 32x32 reciprocal multiplier, each digit by a multiply and then a quotient and
// remainder fix-up, then its characters are emitted. Zero prints as one 0.
// Output stalls hold back character emission. The colour register is written
// through its own port, always ready; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
module console_number_formatter #(
	parameter int DIGIT_SLOTS = cnf_pkg::CNF_DIGIT_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cnf_pkg::cnf_cmd_t cmd,
	// character channel
	output logic              txt_valid,
	input  logic              txt_stall,
	output cnf_pkg::cnf_chr_t txt,
	// colour register write channel
	input  logic              color_valid,
	output logic              color_ready,
	input  logic [7:0]        color_data
);
	import cnf_pkg::*;

	localparam int CW = $clog2(DIGIT_SLOTS + 1);
	localparam int IW = $clog2(DIGIT_SLOTS);
	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam logic [CW-1:0] SLOTS_C = CW'(DIGIT_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHAR,
		S_SIGN,
		S_MUL,
		S_FIX,
		S_HEX,
		S_ZERO,
		S_DIGIT
	} state_t;

	// digit value to ascii
	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

	state_t            state_q;
	logic [7:0]        color_q;
	logic [31:0]       rem_q;
	logic [63:0]       prod_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     emit_idx_q;
	logic [3:0]        dstore_q [DIGIT_SLOTS];
	logic [7:0]        char_q;
	logic [1:0]        step_q;
	logic              txt_valid_q;
	cnf_chr_t          txt_q;

	logic              slot_free;
	logic              emit;
	logic              store_ok;
	logic [CW-1:0]     count_next;
	logic [IW-1:0]     top_idx;
	logic [28:0]       quot;
	logic [3:0]        quot_x10;
	logic [3:0]        dec_digit;
	logic [31:0]       neg_value;
	logic              is_nl;
	logic              is_bs;
	logic [7:0]        exp_code;
	logic              exp_last;

	assign cmd_stall   = (state_q != S_IDLE);
	assign color_ready = 1'b1;
	assign txt_valid   = txt_valid_q;
	assign txt         = txt_q;

	// output register can take a new character
	assign slot_free = !txt_valid_q || !txt_stall;

	// a character is loaded into the output register this cycle
	assign emit = slot_free && ((state_q == S_CHAR) || (state_q == S_SIGN) ||
		(state_q == S_ZERO) || (state_q == S_DIGIT));

	// digit store bookkeeping
	assign store_ok   = (count_q < SLOTS_C);
	assign count_next = count_q + CW'(store_ok);
	assign top_idx    = IW'(count_next - CW'(1));

	// decimal digit from the registered reciprocal product
	assign quot      = prod_q[63:35];
	assign quot_x10  = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign dec_digit = rem_q[3:0] - quot_x10;

	assign neg_value = 32'd0 - cmd.value;

	// character expansion
	assign is_nl = (char_q == CH_CR) || (char_q == CH_LF);
	assign is_bs = (char_q == CH_BS);
	always_comb begin
		exp_code = char_q;
		exp_last = 1'b1;
		if (is_nl) begin
			exp_code = (step_q == 2'd0) ? CH_CR : CH_LF;
			exp_last = (step_q == 2'd1);
		end else if (is_bs) begin
			exp_code = (step_q == 2'd1) ? CH_SPACE : CH_BS;
			exp_last = (step_q == 2'd2);
		end
	end

	// colour register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (color_valid && color_ready) begin
			color_q <= color_data;
		end
	end

	// digit store write
	always_ff @(posedge clk) begin
		if ((state_q == S_FIX) && store_ok) begin
			dstore_q[IW'(count_q)] <= dec_digit;
		end else if ((state_q == S_HEX) && store_ok) begin
			dstore_q[IW'(count_q)] <= rem_q[3:0];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rem_q       <= '0;
			count_q     <= '0;
			emit_idx_q  <= '0;
			step_q      <= '0;
			txt_valid_q <= 1'b0;
			char_q      <= '0;
			prod_q      <= '0;
			txt_q       <= '0;
		end else begin
			// set on a new character, drop once it is transferred
			if (emit) begin
				txt_valid_q <= 1'b1;
			end else if (txt_valid_q && !txt_stall) begin
				txt_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.action)
							ACT_CHAR: begin
								char_q  <= cmd.value[7:0];
								step_q  <= 2'd0;
								state_q <= S_CHAR;
							end
							ACT_DEC: begin
								count_q <= '0;
								if (cmd.value[31]) begin
									rem_q   <= neg_value;
									state_q <= S_SIGN;
								end else begin
									rem_q   <= cmd.value;
									state_q <= (cmd.value == 32'd0) ? S_ZERO : S_MUL;
								end
							end
							ACT_HEX: begin
								count_q <= '0;
								rem_q   <= cmd.value;
								state_q <= (cmd.value == 32'd0) ? S_ZERO : S_HEX;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CHAR: begin
					if (slot_free) begin
						txt_q.char_code <= exp_code;
						txt_q.attribute <= color_q;
						txt_q.last      <= exp_last;
						step_q          <= step_q + 2'd1;
						if (exp_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SIGN: begin
					if (slot_free) begin
						txt_q.char_code <= CH_MINUS;
						txt_q.attribute <= color_q;
						txt_q.last      <= 1'b0;
						state_q         <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= rem_q * RECIP10;
					state_q <= S_FIX;
				end
				S_FIX: begin
					count_q <= count_next;
					rem_q   <= {3'd0, quot};
					if (quot == 29'd0) begin
						emit_idx_q <= top_idx;
						state_q    <= S_DIGIT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_HEX: begin
					count_q <= count_next;
					rem_q   <= {4'd0, rem_q[31:4]};
					if (rem_q[31:4] == 28'd0) begin
						emit_idx_q <= top_idx;
						state_q    <= S_DIGIT;
					end
				end
				S_ZERO: begin
					if (slot_free) begin
						txt_q.char_code <= CH_ZERO;
						txt_q.attribute <= color_q;
						txt_q.last      <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_DIGIT: begin
					if (slot_free) begin
						txt_q.char_code <= digit_ascii(dstore_q[emit_idx_q]);
						txt_q.attribute <= color_q;
						txt_q.last      <= (emit_idx_q == '0);
						if (emit_idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q - IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/cnf_checker.sv @@
// port-level checks for the console number formatter, bound to the top level
`timescale 1ns / 1ps

module cnf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input cnf_pkg::cnf_cmd_t cmd,
	input logic              txt_valid,
	input logic              txt_stall,
	input cnf_pkg::cnf_chr_t txt,
	input logic              color_valid,
	input logic              color_ready,
	input logic [7:0]        color_data
);
	import cnf_pkg::*;

	logic cmd_xfer;
	logic txt_xfer;

	assign cmd_xfer = cmd_valid && !cmd_stall;
	assign txt_xfer = txt_valid && !txt_stall;

	// a stalled character holds
	a_txt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && txt_stall |=> txt_valid && $stable(txt))
		else $error("stalled character changed");

	// an unused request code produces nothing and leaves the port open
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && (cmd.action == ACT_NONE) |=> !cmd_stall)
		else $error("unused request code started work");

	// a number request always keeps the port busy in the cycle after it is taken
	a_num_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && ((cmd.action == ACT_DEC) || (cmd.action == ACT_HEX)) |=> cmd_stall)
		else $error("number request did not occupy the block");

	// an expanded carriage return is followed at once by line feed
	a_cr_lf: assert property (@(posedge clk) disable iff (!arst_n)
		txt_xfer && (txt.char_code == CH_CR) && !txt.last
		|=> txt_valid && (txt.char_code == CH_LF))
		else $error("carriage return not followed by line feed");

	// colour port is always open
	a_color_ready: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> color_ready)
		else $error("colour write refused");

endmodule

bind console_number_formatter cnf_checker u_cnf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_stall   (cmd_stall),
	.cmd         (cmd),
	.txt_valid   (txt_valid),
	.txt_stall   (txt_stall),
	.txt         (txt),
	.color_valid (color_valid),
	.color_ready (color_ready),
	.color_data  (color_data)
);

@@ verif/cnf_stream_check.sv @@
// request and character stream predictor and comparator for the console number formatter
`timescale 1ns / 1ps

module cnf_stream_check #(
	parameter int DIGIT_SLOTS = cnf_pkg::CNF_DIGIT_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  cnf_pkg::cnf_cmd_t cmd,
	input  logic              txt_valid,
	input  logic              txt_stall,
	input  cnf_pkg::cnf_chr_t txt,
	input  logic              color_valid,
	input  logic              color_ready,
	input  logic [7:0]        color_data,
	output int                fail_count,
	output int                pending_chars
);

	import cnf_pkg::*;

	cnf_chr_t   expected_chars[$];
	logic [7:0] text_color;
	int         mismatches;

	initial begin
		mismatches = 0;
		text_color = COLOR_RESET;
		fail_count = 0;
		pending_chars = 0;
	end

	// one line per mismatch, and count it
	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t ns: %s got %02h want %02h", $time, what, got, want);
		mismatches++;
	endtask

	// raw console character with the current attribute
	function automatic void push_glyph(input logic [7:0] code);
		cnf_chr_t ch;
		ch.char_code = code;
		ch.attribute = text_color;
		ch.last = 1'b0;
		expected_chars.push_back(ch);
	endfunction

	// console expansion of line ends and backspace
	function automatic void print_char(input logic [7:0] code);
		if (code == CH_CR || code == CH_LF) begin
			push_glyph(CH_CR);
			push_glyph(CH_LF);
		end else if (code == CH_BS) begin
			push_glyph(CH_BS);
			push_glyph(CH_SPACE);
			push_glyph(CH_BS);
		end else begin
			push_glyph(code);
		end
	endfunction

	// split a magnitude into digits, keep the low slots, print most significant first
	function automatic void print_number(input logic [31:0] mag, input logic [4:0] radix);
		logic [3:0] digits [DIGIT_SLOTS];
		logic [3:0] d;
		int count;
		count = 0;
		if (mag == 32'd0) begin
			print_char(CH_ZERO);
			return;
		end
		while (mag != 32'd0) begin
			d = 4'(mag % radix);
			if (count < DIGIT_SLOTS) begin
				digits[count] = d;
				count++;
			end
			mag = mag / radix;
		end
		for (int i = count - 1; i >= 0; i--) begin
			if (digits[i] < 4'd10)
				print_char(CH_ZERO + 8'(digits[i]));
			else
				print_char(CH_A + 8'(digits[i]) - 8'd10);
		end
	endfunction

	// characters caused by one request, last flag on the final one
	function automatic void predict_request(input cnf_cmd_t req);
		int first;
		cnf_chr_t tail;
		first = expected_chars.size();
		case (req.action)
			ACT_CHAR: print_char(req.value[7:0]);
			ACT_DEC: begin
				if (req.value[31]) begin
					print_char(CH_MINUS);
					print_number(32'd0 - req.value, 5'd10);
				end else begin
					print_number(req.value, 5'd10);
				end
			end
			ACT_HEX: print_number(req.value, 5'd16);
			default: ;
		endcase
		if (expected_chars.size() > first) begin
			tail = expected_chars.pop_back();
			tail.last = 1'b1;
			expected_chars.push_back(tail);
		end
	endfunction

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		cnf_chr_t want;
		if (!arst_n) begin
			text_color = COLOR_RESET;
		end else begin
			if (color_valid && color_ready)
				text_color = color_data;
			// character transfer against the oldest expectation
			if (txt_valid && !txt_stall) begin
				if (expected_chars.size() == 0) begin
					report("unexpected character", txt.char_code, 8'h00);
				end else begin
					want = expected_chars.pop_front();
					if (txt.char_code !== want.char_code)
						report("char_code", txt.char_code, want.char_code);
					if (txt.attribute !== want.attribute)
						report("attribute", txt.attribute, want.attribute);
					if (txt.last !== want.last)
						report("last", 8'(txt.last), 8'(want.last));
				end
			end
			// request transfer
			if (cmd_valid && !cmd_stall)
				predict_request(cmd);
		end
		fail_count <= mismatches;
		pending_chars <= expected_chars.size();
	end

endmodule

@@ verif/console_number_formatter_tb.sv @@
// top of the console number formatter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module console_number_formatter_tb;

	import cnf_pkg::*;

	localparam int SLOTS = CNF_DIGIT_SLOTS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 40;
	localparam logic [31:0] CORNERS [12] = '{
		32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h7FFF_FFFF, 32'd9, 32'd10, 32'd999_999_999, 32'd1_000_000_000,
		32'h0000_000F, 32'h0000_0010, 32'h8000_0001
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	cnf_cmd_t   cmd;
	logic       txt_valid;
	logic       txt_stall;
	cnf_chr_t   txt;
	logic       color_valid;
	logic       color_ready;
	logic [7:0] color_data;
	int         fail_count;
	int         pending_chars;
	int         cycle_count = 0;
	bit         calm = 1'b0;

	console_number_formatter #(.DIGIT_SLOTS(SLOTS)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.txt_valid   (txt_valid),
		.txt_stall   (txt_stall),
		.txt         (txt),
		.color_valid (color_valid),
		.color_ready (color_ready),
		.color_data  (color_data)
	);

	cnf_stream_check #(.DIGIT_SLOTS(SLOTS)) stream_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd           (cmd),
		.txt_valid     (txt_valid),
		.txt_stall     (txt_stall),
		.txt           (txt),
		.color_valid   (color_valid),
		.color_ready   (color_ready),
		.color_data    (color_data),
		.fail_count    (fail_count),
		.pending_chars (pending_chars)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// console side: random stall before each character transfer
	initial begin : console_side
		int hold;
		txt_stall = 1'b0;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				txt_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			txt_stall <= 1'b0;
			@(posedge clk);
			while (!txt_valid) @(posedge clk);
		end
	end

	// one request transfer after a random gap; valid stays high when the next gap is zero
	task automatic send_request(input logic [1:0] action, input logic [31:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd.action <= action;
		cmd.value <= value;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// drop valid, wait for every expected character, then let the block go quiet
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_chars != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// colour register write, only while idle
	task automatic write_color(input logic [7:0] color);
		color_valid <= 1'b1;
		color_data <= color;
		@(posedge clk);
		while (!color_ready) @(posedge clk);
		color_valid <= 1'b0;
	endtask

	// random request, weighted toward corners, short numbers and line control characters
	function automatic cnf_cmd_t random_request();
		cnf_cmd_t req;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			req.action = ACT_NONE;
		else if (pick < 35)
			req.action = ACT_CHAR;
		else if (pick < 70)
			req.action = ACT_DEC;
		else
			req.action = ACT_HEX;
		req.value = $urandom;
		case ($urandom_range(0, 4))
			0: req.value = req.value >> $urandom_range(1, 31);
			1: req.value = 32'd0 - (req.value >> $urandom_range(1, 31));
			2: req.value = CORNERS[$urandom_range(0, 11)];
			default: ;
		endcase
		if (req.action == ACT_CHAR && $urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 2))
				0: req.value[7:0] = CH_CR;
				1: req.value[7:0] = CH_LF;
				default: req.value[7:0] = CH_BS;
			endcase
		end
		return req;
	endfunction

	// stimulus and verdict
	initial begin : stimulus
		cnf_cmd_t req;
		int sent;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		color_valid = 1'b0;
		color_data = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset attribute
		send_request(ACT_CHAR, 32'h0000_0041);
		send_request(ACT_CHAR, {24'hFFFFFF, CH_CR});
		send_request(ACT_CHAR, {24'h000000, CH_LF});
		send_request(ACT_CHAR, {24'h5A5A5A, CH_BS});
		send_request(ACT_CHAR, 32'h0000_0000);
		send_request(ACT_CHAR, 32'hFFFF_FFFF);
		send_request(ACT_CHAR, {24'h0, CH_MINUS});
		send_request(ACT_DEC, 32'h0000_0000);
		send_request(ACT_DEC, 32'h0000_0001);
		send_request(ACT_DEC, 32'hFFFF_FFFF);
		send_request(ACT_DEC, 32'h7FFF_FFFF);
		send_request(ACT_DEC, 32'h8000_0000);
		send_request(ACT_DEC, 32'd1_000_000_000);
		send_request(ACT_DEC, 32'd999_999_999);
		send_request(ACT_HEX, 32'h0000_0000);
		send_request(ACT_HEX, 32'hFFFF_FFFF);
		send_request(ACT_HEX, 32'h0000_000A);
		send_request(ACT_HEX, 32'h0000_0010);
		send_request(ACT_HEX, 32'h8000_0000);
		send_request(ACT_HEX, 32'h89AB_CDEF);
		send_request(ACT_NONE, 32'hFFFF_FFFF);
		send_request(ACT_DEC, 32'h0000_0007);
		settle();

		// random phases under different attributes, one without idling
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_color(8'hFF);
				1: write_color(8'h00);
				default: write_color(8'($urandom_range(0, 255)));
			endcase
			calm = (phase == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				req = random_request();
				send_request(req.action, req.value);
				if (req.action != ACT_NONE)
					sent++;
			end
			settle();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ console_number_formatter.f @@
hdl/cnf_pkg.sv
hdl/console_number_formatter.sv
hdl/cnf_checker.sv
verif/cnf_stream_check.sv
verif/console_number_formatter_tb.sv
